// ----- design/polyline_circle_contact_counter_macros.svh -----
// assertion macros shared by the checker of the contact counter
// needs clk and rst_n in the scope where a macro is used
`ifndef POLYLINE_CIRCLE_CONTACT_COUNTER_MACROS_SVH
`define POLYLINE_CIRCLE_CONTACT_COUNTER_MACROS_SVH

// same-cycle implication
`define PCCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pccc_pkg.sv -----
// types, widths and codes of the polyline circle contact counter
// used by pccc_ctrl, pccc_datapath and the top level; depends on nothing
package pccc_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int RAD_W     = 31;
  localparam int SCALE_W   = 32;
  localparam int COUNT_W   = 12;
  localparam int FRAC_W    = 44;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int COUNT_MAX = 4095;

  // shared multiplier and accumulator
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 68;
  localparam int ACC_W   = 132;
  localparam int LIMB_W  = 33;
  localparam int R2_W    = 62;
  localparam int LEN_W   = 65;
  localparam int DOT_W   = 66;
  localparam int CROSS_W = 67;
  localparam int CMAG_W  = 65;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_SCALE   = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_R2, ST_DOT0, ST_DOT1, ST_LEN0, ST_LEN1, ST_CRS0, ST_CRS1,
    ST_BRANCH, ST_PW0, ST_PW1, ST_PW2, ST_PV0, ST_PV1, ST_PV2,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQ4, ST_SQ5, ST_SQ6, ST_SQ7,
    ST_EVAL, ST_FIN, ST_EMIT
  } pccc_state_t;

  // operand pairs of the shared multiplier
  typedef enum logic [4:0] {
    MUL_HOLD, MUL_R_R, MUL_WX_DX, MUL_WY_DY, MUL_DX_DX, MUL_DY_DY,
    MUL_WX_DY, MUL_WY_DX, MUL_WX_WX, MUL_WY_WY, MUL_VX_VX, MUL_VY_VY,
    MUL_RL_LL, MUL_RL_LH, MUL_RH_LL, MUL_RH_LH,
    MUL_CL_CL, MUL_CL_CH, MUL_CH_CH, MUL_CNT_SCALE
  } pccc_mul_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_SET, ACC_ADD} pccc_acc_op_t;
  typedef enum logic {SRC_PROD, SRC_R2} pccc_acc_src_t;
  typedef enum logic [1:0] {SH_0, SH_33, SH_34, SH_66} pccc_shift_t;

  typedef struct packed {
    logic          take_in;
    pccc_mul_t     mul;
    pccc_acc_op_t  acc_op;
    logic          acc_neg;
    pccc_acc_src_t acc_src;
    pccc_shift_t   acc_shift;
    logic          save_r2;
    logic          save_dot;
    logic          save_len;
    logic          save_cross;
    logic          count_hit;
    logic          load_out;
    logic          clear_run;
  } pccc_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last_pt;
    logic dot_le_zero;
    logic dot_ge_len;
    logic out_stall;
  } pccc_status_t;

endpackage

// ----- design/polyline_circle_contact_counter.sv -----
// channel   dir  beat fields (tdata low bit first)            end of run
// in_       in   point_x[31:0], point_y[63:32]                 in_tlast = last_point
// out_      out  contact_segments[11:0], engulf_fraction[55:12] none
// cfg_      in   cfg_index selects register, cfg_wdata value   n/a
//
// a first vertex is only stored; a segment clamped to an endpoint steps R2..BRANCH,
// PW or PV and EVAL, an interior one SQ0..SQ7 instead; one 34x34 product per cycle
// the last vertex adds FIN for count times scale and EMIT, plus any wait on out_tready
// a new vertex is taken while a result waits in the output register
// rst_n is synchronous; it clears the config registers, the count, the run state and out_tvalid
module polyline_circle_contact_counter #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [pccc_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [pccc_pkg::CFG_W-1:0]                 cfg_wdata,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // point_x [31:0], point_y [63:32]
  input  logic [2*pccc_pkg::COORD_W-1:0]             in_tdata,
  input  logic                                       in_tlast,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // contact_segments [11:0], engulf_fraction [55:12]
  output logic [pccc_pkg::COUNT_W+pccc_pkg::FRAC_W-1:0] out_tdata
);

  pccc_pkg::pccc_cmd_t    cmd;
  pccc_pkg::pccc_status_t status;

  pccc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pccc_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// ----- design/pccc_ctrl.sv -----
// controller of the contact counter: sequences the shared multiplier and
// accumulator one step a cycle outside waits in IDLE and EMIT; depends on pccc_pkg
module pccc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tlast,
  output logic                   in_tready,
  input  pccc_pkg::pccc_status_t status,
  output pccc_pkg::pccc_cmd_t    cmd
);

  pccc_pkg::pccc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pccc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pccc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (status.have_prev) begin
            state_nxt = pccc_pkg::ST_R2;
          end else if (in_tlast) begin
            state_nxt = pccc_pkg::ST_FIN;
          end
        end
      end
      pccc_pkg::ST_R2:     state_nxt = pccc_pkg::ST_DOT0;
      pccc_pkg::ST_DOT0:   state_nxt = pccc_pkg::ST_DOT1;
      pccc_pkg::ST_DOT1:   state_nxt = pccc_pkg::ST_LEN0;
      pccc_pkg::ST_LEN0:   state_nxt = pccc_pkg::ST_LEN1;
      pccc_pkg::ST_LEN1:   state_nxt = pccc_pkg::ST_CRS0;
      pccc_pkg::ST_CRS0:   state_nxt = pccc_pkg::ST_CRS1;
      pccc_pkg::ST_CRS1:   state_nxt = pccc_pkg::ST_BRANCH;
      pccc_pkg::ST_BRANCH: begin
        // projection at or before the first endpoint, at or past the second, or inside
        if (status.dot_le_zero) begin
          state_nxt = pccc_pkg::ST_PW0;
        end else if (status.dot_ge_len) begin
          state_nxt = pccc_pkg::ST_PV0;
        end else begin
          state_nxt = pccc_pkg::ST_SQ0;
        end
      end
      pccc_pkg::ST_PW0: state_nxt = pccc_pkg::ST_PW1;
      pccc_pkg::ST_PW1: state_nxt = pccc_pkg::ST_PW2;
      pccc_pkg::ST_PW2: state_nxt = pccc_pkg::ST_EVAL;
      pccc_pkg::ST_PV0: state_nxt = pccc_pkg::ST_PV1;
      pccc_pkg::ST_PV1: state_nxt = pccc_pkg::ST_PV2;
      pccc_pkg::ST_PV2: state_nxt = pccc_pkg::ST_EVAL;
      pccc_pkg::ST_SQ0: state_nxt = pccc_pkg::ST_SQ1;
      pccc_pkg::ST_SQ1: state_nxt = pccc_pkg::ST_SQ2;
      pccc_pkg::ST_SQ2: state_nxt = pccc_pkg::ST_SQ3;
      pccc_pkg::ST_SQ3: state_nxt = pccc_pkg::ST_SQ4;
      pccc_pkg::ST_SQ4: state_nxt = pccc_pkg::ST_SQ5;
      pccc_pkg::ST_SQ5: state_nxt = pccc_pkg::ST_SQ6;
      pccc_pkg::ST_SQ6: state_nxt = pccc_pkg::ST_SQ7;
      pccc_pkg::ST_SQ7: state_nxt = pccc_pkg::ST_EVAL;
      pccc_pkg::ST_EVAL: begin
        state_nxt = status.last_pt ? pccc_pkg::ST_FIN : pccc_pkg::ST_IDLE;
      end
      pccc_pkg::ST_FIN: state_nxt = pccc_pkg::ST_EMIT;
      pccc_pkg::ST_EMIT: begin
        if (!status.out_stall) begin
          state_nxt = pccc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pccc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.mul       = pccc_pkg::MUL_HOLD;
    cmd.acc_op    = pccc_pkg::ACC_HOLD;
    cmd.acc_src   = pccc_pkg::SRC_PROD;
    cmd.acc_shift = pccc_pkg::SH_0;
    case (state_r)
      pccc_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.take_in = in_tvalid;
      end
      pccc_pkg::ST_R2: cmd.mul = pccc_pkg::MUL_R_R;
      pccc_pkg::ST_DOT0: begin
        cmd.mul     = pccc_pkg::MUL_WX_DX;
        cmd.save_r2 = 1'b1;
      end
      pccc_pkg::ST_DOT1: begin
        cmd.mul    = pccc_pkg::MUL_WY_DY;
        cmd.acc_op = pccc_pkg::ACC_SET;
      end
      pccc_pkg::ST_LEN0: begin
        cmd.mul    = pccc_pkg::MUL_DX_DX;
        cmd.acc_op = pccc_pkg::ACC_ADD;
      end
      pccc_pkg::ST_LEN1: begin
        cmd.mul      = pccc_pkg::MUL_DY_DY;
        cmd.acc_op   = pccc_pkg::ACC_SET;
        cmd.save_dot = 1'b1;
      end
      pccc_pkg::ST_CRS0: begin
        cmd.mul    = pccc_pkg::MUL_WX_DY;
        cmd.acc_op = pccc_pkg::ACC_ADD;
      end
      pccc_pkg::ST_CRS1: begin
        cmd.mul      = pccc_pkg::MUL_WY_DX;
        cmd.acc_op   = pccc_pkg::ACC_SET;
        cmd.save_len = 1'b1;
      end
      pccc_pkg::ST_BRANCH: begin
        cmd.acc_op  = pccc_pkg::ACC_ADD;
        cmd.acc_neg = 1'b1;
      end
      // endpoint distance: acc = -r^2 + x^2 + y^2
      pccc_pkg::ST_PW0, pccc_pkg::ST_PV0: begin
        cmd.mul     = (state_r == pccc_pkg::ST_PW0) ? pccc_pkg::MUL_WX_WX
                                                     : pccc_pkg::MUL_VX_VX;
        cmd.acc_op  = pccc_pkg::ACC_SET;
        cmd.acc_neg = 1'b1;
        cmd.acc_src = pccc_pkg::SRC_R2;
      end
      pccc_pkg::ST_PW1, pccc_pkg::ST_PV1: begin
        cmd.mul    = (state_r == pccc_pkg::ST_PW1) ? pccc_pkg::MUL_WY_WY
                                                    : pccc_pkg::MUL_VY_VY;
        cmd.acc_op = pccc_pkg::ACC_ADD;
      end
      pccc_pkg::ST_PW2, pccc_pkg::ST_PV2: cmd.acc_op = pccc_pkg::ACC_ADD;
      // interior: acc = cross^2 - r^2 * len, one partial product a step
      pccc_pkg::ST_SQ0: begin
        cmd.mul        = pccc_pkg::MUL_RL_LL;
        cmd.save_cross = 1'b1;
      end
      pccc_pkg::ST_SQ1: begin
        cmd.mul     = pccc_pkg::MUL_RL_LH;
        cmd.acc_op  = pccc_pkg::ACC_SET;
        cmd.acc_neg = 1'b1;
      end
      pccc_pkg::ST_SQ2: begin
        cmd.mul       = pccc_pkg::MUL_RH_LL;
        cmd.acc_op    = pccc_pkg::ACC_ADD;
        cmd.acc_neg   = 1'b1;
        cmd.acc_shift = pccc_pkg::SH_33;
      end
      pccc_pkg::ST_SQ3: begin
        cmd.mul       = pccc_pkg::MUL_RH_LH;
        cmd.acc_op    = pccc_pkg::ACC_ADD;
        cmd.acc_neg   = 1'b1;
        cmd.acc_shift = pccc_pkg::SH_33;
      end
      pccc_pkg::ST_SQ4: begin
        cmd.mul       = pccc_pkg::MUL_CL_CL;
        cmd.acc_op    = pccc_pkg::ACC_ADD;
        cmd.acc_neg   = 1'b1;
        cmd.acc_shift = pccc_pkg::SH_66;
      end
      pccc_pkg::ST_SQ5: begin
        cmd.mul    = pccc_pkg::MUL_CL_CH;
        cmd.acc_op = pccc_pkg::ACC_ADD;
      end
      pccc_pkg::ST_SQ6: begin
        // cross term appears twice, hence the extra bit of shift
        cmd.mul       = pccc_pkg::MUL_CH_CH;
        cmd.acc_op    = pccc_pkg::ACC_ADD;
        cmd.acc_shift = pccc_pkg::SH_34;
      end
      pccc_pkg::ST_SQ7: begin
        cmd.acc_op    = pccc_pkg::ACC_ADD;
        cmd.acc_shift = pccc_pkg::SH_66;
      end
      pccc_pkg::ST_EVAL: cmd.count_hit = 1'b1;
      pccc_pkg::ST_FIN:  cmd.mul = pccc_pkg::MUL_CNT_SCALE;
      pccc_pkg::ST_EMIT: begin
        cmd.load_out  = !status.out_stall;
        cmd.clear_run = !status.out_stall;
      end
      default: cmd.mul = pccc_pkg::MUL_HOLD;
    endcase
  end

endmodule

// ----- design/pccc_datapath.sv -----
// datapath of the contact counter: config registers, vertex differences,
// shared 34x34 multiplier, 132-bit accumulator, count and result register
// depends on pccc_pkg
module pccc_datapath #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pccc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pccc_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [2*pccc_pkg::COORD_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [pccc_pkg::COUNT_W+pccc_pkg::FRAC_W-1:0] out_tdata,
  input  pccc_pkg::pccc_cmd_t                 cmd,
  output pccc_pkg::pccc_status_t              status
);

  localparam int LIMIT_I = (MAX_POINTS - 1 < pccc_pkg::COUNT_MAX) ?
                           MAX_POINTS - 1 : pccc_pkg::COUNT_MAX;
  localparam logic [pccc_pkg::COUNT_W-1:0] LIMIT = pccc_pkg::COUNT_W'(LIMIT_I);

  // configuration
  logic signed [pccc_pkg::COORD_W-1:0] cx_r, cy_r;
  logic        [pccc_pkg::RAD_W-1:0]   rad_r;
  logic        [pccc_pkg::SCALE_W-1:0] scale_r;

  // run state
  logic signed [pccc_pkg::COORD_W-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic                                have_prev_r, have_prev_nxt;
  logic                                last_r, last_nxt;
  logic        [pccc_pkg::COUNT_W-1:0] count_r, count_nxt;

  // per-segment working values
  logic signed [pccc_pkg::DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [pccc_pkg::DIFF_W-1:0] wx_r, wx_nxt, wy_r, wy_nxt;
  logic signed [pccc_pkg::DIFF_W-1:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [pccc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [pccc_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic        [pccc_pkg::R2_W-1:0]   r2_r, r2_nxt;
  logic signed [pccc_pkg::DOT_W-1:0]  dot_r, dot_nxt;
  logic        [pccc_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic        [pccc_pkg::CMAG_W-1:0] cross_r, cross_nxt;

  // result register
  logic                                out_valid_r, out_valid_nxt;
  logic        [pccc_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic        [pccc_pkg::FRAC_W-1:0]  out_frac_r, out_frac_nxt;

  logic signed [pccc_pkg::COORD_W-1:0] px, py;
  logic signed [pccc_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [pccc_pkg::ACC_W-1:0]   acc_opnd, acc_sh, acc_term;
  logic signed [pccc_pkg::CROSS_W-1:0] cross_val, cross_abs;
  logic                                acc_le_zero;

  assign px = in_tdata[pccc_pkg::COORD_W-1:0];
  assign py = in_tdata[2*pccc_pkg::COORD_W-1:pccc_pkg::COORD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      rad_r   <= '0;
      scale_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pccc_pkg::CFG_CENTRE_X:       cx_r    <= cfg_wdata;
        pccc_pkg::CFG_CENTRE_Y:       cy_r    <= cfg_wdata;
        pccc_pkg::CFG_CONTACT_RADIUS: rad_r   <= cfg_wdata[pccc_pkg::RAD_W-1:0];
        pccc_pkg::CFG_LENGTH_SCALE:   scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // operand pairs; limbs are zero extended, differences sign extended
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      pccc_pkg::MUL_R_R: begin
        mul_a = $signed(pccc_pkg::MUL_W'(rad_r));
        mul_b = $signed(pccc_pkg::MUL_W'(rad_r));
      end
      pccc_pkg::MUL_WX_DX: begin
        mul_a = pccc_pkg::MUL_W'(wx_r); mul_b = pccc_pkg::MUL_W'(dx_r);
      end
      pccc_pkg::MUL_WY_DY: begin
        mul_a = pccc_pkg::MUL_W'(wy_r); mul_b = pccc_pkg::MUL_W'(dy_r);
      end
      pccc_pkg::MUL_DX_DX: begin
        mul_a = pccc_pkg::MUL_W'(dx_r); mul_b = pccc_pkg::MUL_W'(dx_r);
      end
      pccc_pkg::MUL_DY_DY: begin
        mul_a = pccc_pkg::MUL_W'(dy_r); mul_b = pccc_pkg::MUL_W'(dy_r);
      end
      pccc_pkg::MUL_WX_DY: begin
        mul_a = pccc_pkg::MUL_W'(wx_r); mul_b = pccc_pkg::MUL_W'(dy_r);
      end
      pccc_pkg::MUL_WY_DX: begin
        mul_a = pccc_pkg::MUL_W'(wy_r); mul_b = pccc_pkg::MUL_W'(dx_r);
      end
      pccc_pkg::MUL_WX_WX: begin
        mul_a = pccc_pkg::MUL_W'(wx_r); mul_b = pccc_pkg::MUL_W'(wx_r);
      end
      pccc_pkg::MUL_WY_WY: begin
        mul_a = pccc_pkg::MUL_W'(wy_r); mul_b = pccc_pkg::MUL_W'(wy_r);
      end
      pccc_pkg::MUL_VX_VX: begin
        mul_a = pccc_pkg::MUL_W'(vx_r); mul_b = pccc_pkg::MUL_W'(vx_r);
      end
      pccc_pkg::MUL_VY_VY: begin
        mul_a = pccc_pkg::MUL_W'(vy_r); mul_b = pccc_pkg::MUL_W'(vy_r);
      end
      pccc_pkg::MUL_RL_LL: begin
        mul_a = $signed(pccc_pkg::MUL_W'(r2_r[pccc_pkg::LIMB_W-1:0]));
        mul_b = $signed(pccc_pkg::MUL_W'(len_r[pccc_pkg::LIMB_W-1:0]));
      end
      pccc_pkg::MUL_RL_LH: begin
        mul_a = $signed(pccc_pkg::MUL_W'(r2_r[pccc_pkg::LIMB_W-1:0]));
        mul_b = $signed(pccc_pkg::MUL_W'(len_r[pccc_pkg::LEN_W-1:pccc_pkg::LIMB_W]));
      end
      pccc_pkg::MUL_RH_LL: begin
        mul_a = $signed(pccc_pkg::MUL_W'(r2_r[pccc_pkg::R2_W-1:pccc_pkg::LIMB_W]));
        mul_b = $signed(pccc_pkg::MUL_W'(len_r[pccc_pkg::LIMB_W-1:0]));
      end
      pccc_pkg::MUL_RH_LH: begin
        mul_a = $signed(pccc_pkg::MUL_W'(r2_r[pccc_pkg::R2_W-1:pccc_pkg::LIMB_W]));
        mul_b = $signed(pccc_pkg::MUL_W'(len_r[pccc_pkg::LEN_W-1:pccc_pkg::LIMB_W]));
      end
      pccc_pkg::MUL_CL_CL: begin
        mul_a = $signed(pccc_pkg::MUL_W'(cross_r[pccc_pkg::LIMB_W-1:0]));
        mul_b = $signed(pccc_pkg::MUL_W'(cross_r[pccc_pkg::LIMB_W-1:0]));
      end
      pccc_pkg::MUL_CL_CH: begin
        mul_a = $signed(pccc_pkg::MUL_W'(cross_r[pccc_pkg::LIMB_W-1:0]));
        mul_b = $signed(pccc_pkg::MUL_W'(cross_r[pccc_pkg::CMAG_W-1:pccc_pkg::LIMB_W]));
      end
      pccc_pkg::MUL_CH_CH: begin
        mul_a = $signed(pccc_pkg::MUL_W'(cross_r[pccc_pkg::CMAG_W-1:pccc_pkg::LIMB_W]));
        mul_b = $signed(pccc_pkg::MUL_W'(cross_r[pccc_pkg::CMAG_W-1:pccc_pkg::LIMB_W]));
      end
      pccc_pkg::MUL_CNT_SCALE: begin
        mul_a = $signed(pccc_pkg::MUL_W'(count_r));
        mul_b = $signed(pccc_pkg::MUL_W'(scale_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // accumulator operand: product or r^2, shifted into its limb position
  always_comb begin
    if (cmd.acc_src == pccc_pkg::SRC_R2) begin
      acc_opnd = $signed(pccc_pkg::ACC_W'(r2_r));
    end else begin
      acc_opnd = pccc_pkg::ACC_W'(prod_r);
    end
    case (cmd.acc_shift)
      pccc_pkg::SH_0:  acc_sh = acc_opnd;
      pccc_pkg::SH_33: acc_sh = acc_opnd <<< 33;
      pccc_pkg::SH_34: acc_sh = acc_opnd <<< 34;
      pccc_pkg::SH_66: acc_sh = acc_opnd <<< 66;
      default:         acc_sh = acc_opnd;
    endcase
    acc_term = cmd.acc_neg ? -acc_sh : acc_sh;
  end

  assign acc_le_zero = acc_r[pccc_pkg::ACC_W-1] || (acc_r == '0);
  assign cross_val   = acc_r[pccc_pkg::CROSS_W-1:0];
  assign cross_abs   = cross_val[pccc_pkg::CROSS_W-1] ? -cross_val : cross_val;

  always_comb begin
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    have_prev_nxt = have_prev_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    r2_nxt        = r2_r;
    dot_nxt       = dot_r;
    len_nxt       = len_r;
    cross_nxt     = cross_r;
    out_count_nxt = out_count_r;
    out_frac_nxt  = out_frac_r;
    out_valid_nxt = out_valid_r && !out_tready;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;

    if (cmd.take_in) begin
      // w runs from the older vertex to the centre, v from the new one
      dx_nxt        = pccc_pkg::DIFF_W'(px) - pccc_pkg::DIFF_W'(prev_x_r);
      dy_nxt        = pccc_pkg::DIFF_W'(py) - pccc_pkg::DIFF_W'(prev_y_r);
      wx_nxt        = pccc_pkg::DIFF_W'(cx_r) - pccc_pkg::DIFF_W'(prev_x_r);
      wy_nxt        = pccc_pkg::DIFF_W'(cy_r) - pccc_pkg::DIFF_W'(prev_y_r);
      vx_nxt        = pccc_pkg::DIFF_W'(cx_r) - pccc_pkg::DIFF_W'(px);
      vy_nxt        = pccc_pkg::DIFF_W'(cy_r) - pccc_pkg::DIFF_W'(py);
      prev_x_nxt    = px;
      prev_y_nxt    = py;
      have_prev_nxt = 1'b1;
      last_nxt      = in_tlast;
    end

    if (cmd.mul != pccc_pkg::MUL_HOLD) begin
      prod_nxt = mul_a * mul_b;
    end

    case (cmd.acc_op)
      pccc_pkg::ACC_SET: acc_nxt = acc_term;
      pccc_pkg::ACC_ADD: acc_nxt = acc_r + acc_term;
      default:           acc_nxt = acc_r;
    endcase

    if (cmd.save_r2)    r2_nxt    = prod_r[pccc_pkg::R2_W-1:0];
    if (cmd.save_dot)   dot_nxt   = acc_r[pccc_pkg::DOT_W-1:0];
    if (cmd.save_len)   len_nxt   = acc_r[pccc_pkg::LEN_W-1:0];
    if (cmd.save_cross) cross_nxt = cross_abs[pccc_pkg::CMAG_W-1:0];

    if (cmd.count_hit && acc_le_zero && (count_r < LIMIT)) begin
      count_nxt = count_r + pccc_pkg::COUNT_W'(1);
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = count_r;
      out_frac_nxt  = prod_r[pccc_pkg::FRAC_W-1:0];
    end

    if (cmd.clear_run) begin
      prev_x_nxt    = '0;
      prev_y_nxt    = '0;
      have_prev_nxt = 1'b0;
      count_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      last_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      have_prev_r <= have_prev_nxt;
      last_r      <= last_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    wx_r        <= wx_nxt;
    wy_r        <= wy_nxt;
    vx_r        <= vx_nxt;
    vy_r        <= vy_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    r2_r        <= r2_nxt;
    dot_r       <= dot_nxt;
    len_r       <= len_nxt;
    cross_r     <= cross_nxt;
    out_count_r <= out_count_nxt;
    out_frac_r  <= out_frac_nxt;
  end

  assign status.have_prev   = have_prev_r;
  assign status.last_pt     = last_r;
  assign status.dot_le_zero = dot_r[pccc_pkg::DOT_W-1] || (dot_r == '0);
  assign status.dot_ge_len  = dot_r >= $signed({1'b0, len_r});
  assign status.out_stall   = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_frac_r, out_count_r};

endmodule

// ----- design/pccc_checker.sv -----
// port-level checks of the contact counter, bound to the top level
// depends on polyline_circle_contact_counter_macros.svh
`include "polyline_circle_contact_counter_macros.svh"

module pccc_checker #(
  parameter int MAX_POINTS = 4096
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  localparam int LIMIT_I = (MAX_POINTS - 1 < 4095) ? MAX_POINTS - 1 : 4095;
  localparam logic [11:0] LIMIT = 12'(LIMIT_I);

  `PCCC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `PCCC_ASSERT_NOW(a_count_limit, out_tvalid, out_tdata[11:0] <= LIMIT, "contact count above saturation limit")
  `PCCC_ASSERT_NOW(a_zero_fraction, out_tvalid && (out_tdata[11:0] == 12'd0), out_tdata[55:12] == 44'd0, "nonzero fraction with zero count")
  `PCCC_ASSERT_NEXT(a_last_busy, in_tvalid && in_tready && in_tlast, !in_tready, "input taken right after a last vertex")
  `PCCC_ASSERT_NOW(a_result_after_busy, $rose(out_tvalid), $past(!in_tready), "result appeared while input was open")

endmodule

bind polyline_circle_contact_counter pccc_checker #(
  .MAX_POINTS (MAX_POINTS)
) u_pccc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
